// File: rtl/core/utf8_sanitizer_top_assert.svh
// Assertion macros shared by the utf8_sanitizer RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef UTF8_SANITIZER_TOP_ASSERT_SVH
`define UTF8_SANITIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8S_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/u8s_pkg.sv
// Shared types and constants for the utf8_sanitizer block.
// No dependencies.
package u8s_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [1:0] REPL_LAST_PH = 2'd2;

  // One item's worth of output: repl_cnt replacement characters first,
  // then lit_cnt bytes taken verbatim from lit[0..].
  typedef struct packed {
    logic [2:0]      repl_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lit;
    logic            last;
  } job_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] ph);
    logic [7:0] b;
    case (ph)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/u8s_front.sv
// Front end: accepts input bytes, tracks the held sequence and decodes each
// item into an output job. Depends on u8s_pkg.
module u8s_front import u8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]  hc_q, hc_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;
  logic [7:0]  held_q [3];
  logic        held_we;
  logic [1:0]  held_idx;

  logic        accept, is_cont, complete, bad, do_fresh;
  logic [20:0] acc_n, min_cp;
  logic [2:0]  hc_p1;
  logic [2:0]  repl;
  logic [2:0]  lit_cnt;
  logic [3:0][7:0] lit;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;

  assign is_cont  = (in_byte_i[7:6] == 2'b10);
  assign acc_n    = {acc_q[14:0], in_byte_i[5:0]};
  assign hc_p1    = {1'b0, hc_q} + 3'd1;
  assign complete = (hc_p1 == len_q);

  always_comb begin
    case (len_q)
      3'd2:    min_cp = 21'h000080;
      3'd3:    min_cp = 21'h000800;
      default: min_cp = 21'h010000;
    endcase
    bad = (acc_n < min_cp) || (acc_n > 21'h10FFFF) ||
          (acc_n inside {[21'h00D800:21'h00DFFF]});
  end

  always_comb begin
    hc_d     = hc_q;
    len_d    = len_q;
    acc_d    = acc_q;
    held_we  = 1'b0;
    held_idx = hc_q;
    repl     = 3'd0;
    lit_cnt  = 3'd0;
    lit      = {8'h00, held_q[2], held_q[1], held_q[0]};
    do_fresh = 1'b0;

    if (hc_q == 2'd0) begin
      do_fresh = 1'b1;
    end else if (!is_cont) begin
      // broken sequence: one replacement per held byte, then restart
      repl     = {1'b0, hc_q};
      do_fresh = 1'b1;
    end else if (complete) begin
      if (bad) begin
        repl = hc_p1;
      end else begin
        lit[hc_q] = in_byte_i;
        lit_cnt   = hc_p1;
      end
      hc_d  = 2'd0;
      len_d = 3'd0;
      acc_d = '0;
    end else if (in_last_i) begin
      repl  = hc_p1;  // truncated tail
      hc_d  = 2'd0;
      len_d = 3'd0;
      acc_d = '0;
    end else begin
      held_we = 1'b1;
      hc_d    = hc_p1[1:0];
      acc_d   = acc_n;
    end

    if (do_fresh) begin
      hc_d  = 2'd0;
      len_d = 3'd0;
      acc_d = '0;
      case (in_byte_i) inside
        [8'h00:8'h7F]: begin
          lit[0]  = in_byte_i;
          lit_cnt = 3'd1;
        end
        [8'hC0:8'hDF], [8'hE0:8'hEF], [8'hF0:8'hF7]: begin
          if (in_last_i) begin
            repl = repl + 3'd1;
          end else begin
            held_we  = 1'b1;
            held_idx = 2'd0;
            hc_d     = 2'd1;
            if (in_byte_i[7:5] == 3'b110) begin
              len_d = 3'd2;
              acc_d = {16'd0, in_byte_i[4:0]};
            end else if (in_byte_i[7:4] == 4'b1110) begin
              len_d = 3'd3;
              acc_d = {17'd0, in_byte_i[3:0]};
            end else begin
              len_d = 3'd4;
              acc_d = {18'd0, in_byte_i[2:0]};
            end
          end
        end
        default: repl = repl + 3'd1;
      endcase
    end
  end

  assign push_o           = accept & ((repl != 3'd0) | (lit_cnt != 3'd0));
  assign job_o.repl_cnt   = repl;
  assign job_o.lit_cnt    = lit_cnt;
  assign job_o.lit        = lit;
  assign job_o.last       = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= 2'd0;
      len_q <= 3'd0;
      acc_q <= '0;
    end else if (accept) begin
      hc_q  <= hc_d;
      len_q <= len_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_we) begin
      held_q[held_idx] <= in_byte_i;
    end
  end

endmodule

// File: rtl/core/u8s_queue.sv
// Short job queue between the front and back ends.
// Depends on u8s_pkg.
module u8s_queue import u8s_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wr_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t rd_job_o
);

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o   = (cnt_q == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign valid_o  = (cnt_q != '0);
  assign rd_job_o = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= wr_job_i;
    end
  end

endmodule

// File: rtl/core/u8s_back.sv
// Back end: expands one job into output bytes, one per cycle while out_ready_i is high.
// Depends on u8s_pkg and utf8_sanitizer_top_assert.svh.
`include "utf8_sanitizer_top_assert.svh"
module u8s_back import u8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       stream_end_o
);

  logic            busy_q;
  logic [2:0]      rep_left_q;
  logic [1:0]      ph_q;
  logic [1:0]      lit_pos_q;
  logic [2:0]      lit_left_q;
  logic [3:0][7:0] lit_q;
  logic            last_q;

  logic fire, final_b, load;
  logic has_rep, has_lit, counts_ok;

  assign fire    = busy_q & out_ready_i;
  assign final_b = ((rep_left_q == 3'd1) && (ph_q == REPL_LAST_PH) && (lit_left_q == 3'd0)) ||
                   ((rep_left_q == 3'd0) && (lit_left_q == 3'd1));
  assign load    = q_valid_i & (~busy_q | (fire & final_b));
  assign pop_o   = load;

  assign out_valid_o  = busy_q;
  assign out_byte_o   = (rep_left_q != 3'd0) ? repl_byte(ph_q) : lit_q[lit_pos_q];
  assign run_end_o    = final_b;
  assign stream_end_o = final_b & last_q;

  // terms for the checks below
  assign has_rep   = (rep_left_q != 3'd0);
  assign has_lit   = (lit_left_q != 3'd0);
  assign counts_ok = (rep_left_q <= 3'd4) && (lit_left_q <= 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rep_left_q <= 3'd0;
      ph_q       <= 2'd0;
      lit_pos_q  <= 2'd0;
      lit_left_q <= 3'd0;
      lit_q      <= '0;
      last_q     <= 1'b0;
    end else if (load) begin
      busy_q     <= 1'b1;
      rep_left_q <= q_job_i.repl_cnt;
      ph_q       <= 2'd0;
      lit_pos_q  <= 2'd0;
      lit_left_q <= q_job_i.lit_cnt;
      lit_q      <= q_job_i.lit;
      last_q     <= q_job_i.last;
    end else if (fire) begin
      if (final_b) begin
        busy_q <= 1'b0;
      end else if (rep_left_q != 3'd0) begin
        if (ph_q == REPL_LAST_PH) begin
          ph_q       <= 2'd0;
          rep_left_q <= rep_left_q - 3'd1;
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end else begin
        lit_pos_q  <= lit_pos_q + 2'd1;
        lit_left_q <= lit_left_q - 3'd1;
      end
    end
  end

  `U8S_ASSERT_NOW(a_stream_end_on_run_end, stream_end_o, run_end_o, "stream_end without run_end")
  `U8S_ASSERT_NOW(a_job_not_empty, busy_q, has_rep || has_lit, "active job has no bytes left")
  `U8S_ASSERT_NOW(a_counts_bounded, busy_q, counts_ok, "job counts out of range")
  `U8S_ASSERT_NEXT(a_drain_to_idle, fire && final_b && !q_valid_i, !busy_q, "still busy")

endmodule

// File: rtl/core/utf8_sanitizer_top.sv
// utf8_sanitizer top level: streaming UTF-8 validator with U+FFFD replacement.
// Instantiates u8s_front, u8s_queue and u8s_back; depends on u8s_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one byte per item with an
//   end-of-stream flag. Output channel (out_valid_o/out_ready_i) gives one
//   byte per item, with run_end_o on the last byte caused by an input item
//   and stream_end_o on the final byte of a stream.
//   The front end decodes each input item into a job (replacement count plus
//   verbatim bytes) and pushes it into a 4-entry job queue; the back end
//   plays jobs out at one output byte per cycle while out_ready_i is high.
//   The job is registered in the queue and then loaded into the back end's
//   registers before the first output byte of an item is valid.
//   The input takes one item per cycle while each item yields at most one
//   output byte and out_ready_i stays high; an item can yield up to 12
//   bytes (a broken 4-byte form followed by a bad byte), and the input
//   stalls once the job queue is full.
//   A lead byte and its continuation bytes yield no output until the
//   sequence completes or fails.
//   Reset (rst_ni low) clears the held sequence, empties the queue and drops
//   out_valid_o. When out_ready_i is low the current byte is held stable;
//   the front keeps accepting until the queue fills.
module utf8_sanitizer_top import u8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       stream_end_o
);

  // front -> queue
  logic push;
  job_t wr_job;
  logic q_full;

  // queue -> back
  logic q_valid;
  logic pop;
  job_t rd_job;

  u8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (wr_job)
  );

  u8s_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_job_i (wr_job),
    .pop_i    (pop),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .rd_job_o (rd_job)
  );

  u8s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (rd_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

endmodule

// File: dv/tb_utf8_sanitizer_top.sv
// Self-checking testbench for utf8_sanitizer_top: byte stream in, sanitized UTF-8 out.
// Depends on u8s_pkg (replacement byte constants) and the utf8_sanitizer RTL.
`timescale 1ns / 100ps

module tb_utf8_sanitizer_top;
  import u8s_pkg::*;

  // Run shape
  localparam int DIR_N     = 25;
  localparam int RAND_N    = 405;
  localparam int CALM_N    = 60;    // tail of the run with no idling on either side
  localparam int HOLD_AT   = 12;    // random item index where the long output hold starts
  localparam int LONG_HOLD = 80;    // cycles the receiver holds off
  localparam int TAIL_CYC  = 16;    // settle time after the last expected byte
  localparam int WD_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int MAX_OUT   = 12;    // most output bytes one input item can cause

  // Code point bounds
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2 = 21'h000080;
  localparam logic [20:0] MIN_CP3 = 21'h000800;
  localparam logic [20:0] MIN_CP4 = 21'h010000;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    CHK_MODEL,  // from the predictor
    CHK_SAME,   // the byte itself comes back
    CHK_REPL    // one U+FFFD
  } row_chk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    row_chk_e   chk;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } out_item_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       in_last_i     = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_end_o;
  logic       stream_end_o;

  utf8_sanitizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .stream_end_o(stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Directed items: extremes, bad leads, every failure kind, truncation, end of stream.
  dir_row_t dir_tab [DIR_N] = '{
    '{8'h00, 1'b0, CHK_SAME},  '{8'h7F, 1'b0, CHK_SAME},
    '{8'h80, 1'b0, CHK_REPL},  '{8'hFF, 1'b0, CHK_REPL},   // stray continuation, bad lead
    '{8'hC3, 1'b0, CHK_MODEL}, '{8'hA9, 1'b0, CHK_MODEL},  // good 2-byte form
    '{8'hC0, 1'b0, CHK_MODEL}, '{8'h80, 1'b0, CHK_MODEL},  // overlong
    '{8'hED, 1'b0, CHK_MODEL}, '{8'hA0, 1'b0, CHK_MODEL},  // surrogate
    '{8'h80, 1'b0, CHK_MODEL},
    '{8'hF4, 1'b0, CHK_MODEL}, '{8'h90, 1'b0, CHK_MODEL},  // above U+10FFFF
    '{8'h80, 1'b0, CHK_MODEL}, '{8'h80, 1'b0, CHK_MODEL},
    '{8'hE2, 1'b0, CHK_MODEL}, '{8'h41, 1'b0, CHK_MODEL},  // non-continuation
    '{8'hF0, 1'b0, CHK_MODEL}, '{8'h9F, 1'b0, CHK_MODEL},  // three held, then a bad lead:
    '{8'h98, 1'b0, CHK_MODEL}, '{8'hFF, 1'b0, CHK_MODEL},  // the full twelve bytes
    '{8'hC3, 1'b1, CHK_REPL},                              // lead byte ends the stream
    '{8'hE2, 1'b0, CHK_MODEL}, '{8'h82, 1'b1, CHK_MODEL},  // truncated tail
    '{8'h41, 1'b1, CHK_SAME}
  };

  // Predictor state: a copy of the decoder's held sequence
  logic [7:0]  hold_buf [3];
  logic [1:0]  hold_n   = '0;
  logic [2:0]  want_len = '0;
  logic [20:0] cp_acc   = '0;

  out_item_t step_q[$];      // bytes caused by the item just accepted
  out_item_t exp_bytes_q[$]; // output bytes still owed by the block
  in_item_t  rand_q[$];      // random items waiting to be sent
  logic [7:0] enc_q[$];      // one encoded sequence under construction

  int  err_cnt    = 0;
  int  hold_req   = 0;
  int  hold_seen  = 0;
  int  stall_left = 0;
  int  idle_cyc   = 0;
  bit  calm       = 1'b0;
  out_item_t head;

  function automatic void emit(logic [7:0] b);
    out_item_t it;
    it = '{data: b, run_end: 1'b0, stream_end: 1'b0};
    if (step_q.size() < MAX_OUT) step_q.insert(step_q.size(), it);
  endfunction

  function automatic void emit_repl();
    emit(REPL_B0);
    emit(REPL_B1);
    emit(REPL_B2);
  endfunction

  function automatic void drop_seq();
    hold_n   = '0;
    want_len = '0;
    cp_acc   = '0;
  endfunction

  // Flags go on the last byte an item causes
  function automatic void close_run(logic last);
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_end    = 1'b1;
      step_q[step_q.size() - 1].stream_end = last;
    end
  endfunction

  // A byte seen with nothing held: ASCII passes, a lead starts a sequence
  function automatic void start_fresh(logic [7:0] b, logic last);
    logic [2:0]  len;
    logic [20:0] acc;
    len = '0;
    acc = '0;
    if (b[7] == 1'b0) begin
      emit(b);
      return;
    end
    if (b[7:5] == 3'b110) begin
      len = 3'd2;
      acc = 21'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
      acc = 21'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
      acc = 21'(b[2:0]);
    end
    // bad lead, or a lead that ends the stream
    if (len == 3'd0 || last) begin
      emit_repl();
      return;
    end
    hold_buf[0] = b;
    hold_n      = 2'd1;
    want_len    = len;
    cp_acc      = acc;
  endfunction

  // Expected output bytes for one accepted input item, left in step_q
  function automatic void sanitize_step(logic [7:0] b, logic last);
    logic [20:0] floor_cp;
    logic        bad;
    step_q.delete();
    if (hold_n == 2'd0 || want_len < 3'd2 || want_len > 3'd4) begin
      drop_seq();
      start_fresh(b, last);
    end else if (b[7:6] != 2'b10) begin
      repeat (int'(hold_n)) emit_repl();
      drop_seq();
      start_fresh(b, last);
    end else begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      if (int'(hold_n) + 1 == int'(want_len)) begin
        case (want_len)
          3'd2:    floor_cp = MIN_CP2;
          3'd3:    floor_cp = MIN_CP3;
          default: floor_cp = MIN_CP4;
        endcase
        bad = (cp_acc < floor_cp) || (cp_acc > CP_MAX) ||
              (cp_acc >= SURR_LO && cp_acc <= SURR_HI);
        if (bad) begin
          repeat (int'(hold_n) + 1) emit_repl();
        end else begin
          for (int k = 0; k < int'(hold_n); k++) emit(hold_buf[k]);
          emit(b);
        end
        drop_seq();
      end else if (last) begin
        repeat (int'(hold_n) + 1) emit_repl();
        drop_seq();
      end else if (hold_n < 2'd3) begin
        hold_buf[hold_n] = b;
        hold_n           = hold_n + 2'd1;
      end else begin
        drop_seq();
      end
    end
    close_run(last);
  endfunction

  // Append one byte to the sequence under construction
  function automatic void enc_add(logic [7:0] b);
    enc_q.insert(enc_q.size(), b);
  endfunction

  // UTF-8 encoding of cp in len bytes; overlong and out-of-range on purpose when asked
  function automatic void encode_cp(logic [20:0] cp, int len);
    case (len)
      1: enc_add({1'b0, cp[6:0]});
      2: begin
        enc_add({3'b110, cp[10:6]});
        enc_add({2'b10, cp[5:0]});
      end
      3: begin
        enc_add({4'b1110, cp[15:12]});
        enc_add({2'b10, cp[11:6]});
        enc_add({2'b10, cp[5:0]});
      end
      default: begin
        enc_add({5'b11110, cp[20:18]});
        enc_add({2'b10, cp[17:12]});
        enc_add({2'b10, cp[11:6]});
        enc_add({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] valid_cp(int len);
    logic [20:0] cp;
    case (len)
      2: cp = 21'($urandom_range(32'h80, 32'h7FF));
      3: begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h1000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  // Mostly well-formed text with random content, plus every kind of damage
  function automatic void push_seq();
    int          kind;
    int          len;
    int          pos;
    logic [7:0]  b;
    in_item_t    it;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    enc_q.delete();
    if (kind < 25) begin
      encode_cp(21'($urandom_range(0, 127)), 1);
    end else if (kind < 75) begin
      len = (kind < 45) ? 2 : (kind < 62) ? 3 : 4;
      encode_cp(valid_cp(len), len);
    end else if (kind < 80) begin
      // overlong: value fits a shorter form
      case (len)
        2:       encode_cp(21'($urandom_range(0, 32'h7F)), 2);
        3:       encode_cp(21'($urandom_range(0, 32'h7FF)), 3);
        default: encode_cp(21'($urandom_range(0, 32'hFFFF)), 4);
      endcase
    end else if (kind < 84) begin
      encode_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
    end else if (kind < 88) begin
      encode_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
    end else if (kind < 93) begin
      // truncated: next sequence starts early
      encode_cp(valid_cp(len), len);
      repeat ($urandom_range(1, len - 1)) enc_q.delete(enc_q.size() - 1);
    end else if (kind < 96) begin
      // a continuation slot gets a byte that is not 10xxxxxx
      encode_cp(valid_cp(len), len);
      pos = $urandom_range(1, len - 1);
      b   = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b = b ^ 8'h40;
      enc_q[pos] = b;
    end else begin
      repeat ($urandom_range(1, 3)) enc_add(8'($urandom_range(0, 255)));
    end
    foreach (enc_q[k]) begin
      it.data = enc_q[k];
      it.last = ($urandom_range(0, 24) == 0);
      rand_q.insert(rand_q.size(), it);
    end
  endfunction

  // Offer one item and hold it until taken, then book what it should produce
  task automatic send_item(logic [7:0] b, logic last, row_chk_e chk);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sanitize_step(b, last);
    if (chk != CHK_MODEL) begin
      step_q.delete();
      if (chk == CHK_SAME) emit(b);
      else emit_repl();
      close_run(last);
    end
    foreach (step_q[k]) exp_bytes_q.insert(exp_bytes_q.size(), step_q[k]);
  endtask

  // Sender goes quiet until the block owes nothing
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_bytes_q.size() != 0);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Output side: compare each taken byte with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_bytes_q.size() == 0) begin
        $error("out_byte: expected nothing, got %02h", out_byte_o);
        err_cnt++;
      end else begin
        head = exp_bytes_q.pop_front();
        check_field("out_byte", head.data, out_byte_o);
        check_field("run_end", 8'(head.run_end), 8'(run_end_o));
        check_field("stream_end", 8'(head.stream_end), 8'(stream_end_o));
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the calm tail
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  = hold_req;
      stall_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: nothing moving on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= WD_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_item_t item;
    int       sent;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_tab[i].data, dir_tab[i].last, dir_tab[i].chk);
    end
    wait_drained();

    // Random part. Early on the receiver holds off long enough to back the
    // queue up into the input; halfway the sender waits for a full drain.
    while (sent < RAND_N) begin
      if (rand_q.size() == 0) push_seq();
      item = rand_q.pop_front();
      calm = (sent >= RAND_N - CALM_N);
      if (sent == HOLD_AT) hold_req++;
      if (sent == RAND_N / 2) begin
        wait_drained();
      end else if (!calm && (sent < HOLD_AT || sent > HOLD_AT + 20) &&
                   $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      send_item(item.data, item.last, CHK_MODEL);
      sent++;
    end

    // Let the block finish, then watch a little longer for stray bytes
    in_valid_i <= 1'b0;
    while (exp_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: utf8_sanitizer_top.f
+incdir+rtl/core
rtl/core/u8s_pkg.sv
rtl/core/u8s_front.sv
rtl/core/u8s_queue.sv
rtl/core/u8s_back.sv
rtl/core/utf8_sanitizer_top.sv
dv/tb_utf8_sanitizer_top.sv
